>>> rtl/adpu_pkg.sv
// Shared types, constants and codes for the axis delta packer/unpacker.
// Used by adpu_ctrl, adpu_dp and axis_delta_packer_unpacker; depends on nothing.
`default_nettype none

package adpu_pkg;

  // Field widths
  localparam int TYPE_W     = 8;
  localparam int CODE_W     = 16;
  localparam int VALUE_W    = 32;
  localparam int HALF_W     = 16;
  localparam int COUNT_W    = 3;
  localparam int DATA_W     = CODE_W + VALUE_W;
  localparam int IN_USER_W  = TYPE_W;
  localparam int OUT_USER_W = 2 + TYPE_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Axis code registers present in the register map
  localparam int NUM_AXIS_REGS = 4;
  localparam int MAX_AXES_DEF  = 4;

  // Register reset values
  localparam logic [TYPE_W-1:0]  EVENT_TYPE_RST    = 8'd2;
  localparam logic               UNPACK_MODE_RST   = 1'b0;
  localparam logic [CODE_W-1:0]  COMBINED_CODE_RST = 16'd0;
  localparam logic [COUNT_W-1:0] CODE_COUNT_RST    = 3'd2;
  localparam logic [CODE_W-1:0]  AXIS_CODE_0_RST   = 16'd0;
  localparam logic [CODE_W-1:0]  AXIS_CODE_1_RST   = 16'd1;
  localparam logic [CODE_W-1:0]  AXIS_CODE_2_RST   = 16'd0;
  localparam logic [CODE_W-1:0]  AXIS_CODE_3_RST   = 16'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVENT_TYPE    = 3'd0,
    REG_UNPACK_MODE   = 3'd1,
    REG_COMBINED_CODE = 3'd2,
    REG_CODE_COUNT    = 3'd3,
    REG_AXIS_CODE_0   = 3'd4,
    REG_AXIS_CODE_1   = 3'd5,
    REG_AXIS_CODE_2   = 3'd6,
    REG_AXIS_CODE_3   = 3'd7
  } cfg_reg_t;

  // Result disposition codes
  typedef enum logic [1:0] {
    DISP_PASS    = 2'd0,
    DISP_CONSUME = 2'd1,
    DISP_REPORT  = 2'd2
  } disp_t;

  // How an accepted item is handled
  typedef enum logic [1:0] {
    CLS_PASS    = 2'd0,
    CLS_CONSUME = 2'd1,
    CLS_PACK    = 2'd2,
    CLS_UNPACK  = 2'd3
  } cls_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PACK = 2'd1,
    ST_EMIT = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // item accepted this cycle
    logic pack_step;  // fold one slot into the packed word
    logic report;     // load the next unpack report
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cls_t cls;        // class of the item on the input port
    logic idx_top;    // pack sweep is at its final slot
    logic out_last;   // held result is the final one of its item
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/adpu_ctrl.sv
// Sequencing state machine for the axis delta packer/unpacker.
// Depends on adpu_pkg; drives adpu_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module adpu_ctrl
  import adpu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          case (st.cls)
            CLS_PACK:   state_nxt = ST_PACK;
            CLS_UNPACK: state_nxt = ST_EMIT;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_PACK: begin
        // sweep one slot a cycle; the final slot loads the result
        cmd.pack_step = 1'b1;
        if (st.idx_top) begin
          state_nxt = ST_OUT;
        end
      end
      ST_EMIT: begin
        cmd.report = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (st.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            // replace the taken report with the next one
            cmd.report = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/adpu_dp.sv
// Datapath of the axis delta packer/unpacker: registers, delta store,
// code match, packing and splitting, output register. Depends on adpu_pkg.
`default_nettype none

module adpu_dp
  import adpu_pkg::*;
#(
  parameter int MAX_AXES = MAX_AXES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input item fields
  input  wire logic [TYPE_W-1:0]     in_type,
  input  wire logic [CODE_W-1:0]     in_code,
  input  wire logic [VALUE_W-1:0]    in_value,
  input  wire logic                  in_sync,
  // result item fields
  output disp_t                      out_disp,
  output logic [TYPE_W-1:0]          out_type,
  output logic [CODE_W-1:0]          out_code,
  output logic [VALUE_W-1:0]         out_value,
  output logic                       out_sync,
  output logic                       out_last,
  // controller link
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   st
);

  localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  // Configuration registers
  logic [TYPE_W-1:0]  event_type_r;
  logic               unpack_mode_r;
  logic [CODE_W-1:0]  combined_code_r;
  logic [COUNT_W-1:0] code_count_r;
  logic [CODE_W-1:0]  axis_code_r [NUM_AXIS_REGS];

  // Delta store and working registers
  logic [HALF_W-1:0]  held_r [MAX_AXES];
  logic [VALUE_W-1:0] word_r;
  logic [AXW-1:0]     idx_r;
  logic [TYPE_W-1:0]  type_r;

  // Output register
  disp_t              out_disp_r;
  logic [TYPE_W-1:0]  out_type_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_sync_r;
  logic               out_last_r;

  logic [COUNT_W-1:0] n_used;
  logic [COUNT_W-1:0] n_m1;
  logic [MAX_AXES-1:0] hit;
  logic               match_any;
  logic [AXW-1:0]     match_idx;
  cls_t               cls;
  logic               store_en;
  logic [CODE_W-1:0]  axis_sel;
  logic [HALF_W-1:0]  held_sel;

  assign cfg_ready = 1'b1;

  // Clamp the axis count to the store depth
  assign n_used = (code_count_r > COUNT_W'(MAX_AXES)) ? COUNT_W'(MAX_AXES) : code_count_r;
  assign n_m1   = n_used - COUNT_W'(1);

  // Compare the code against every axis in use
  always_comb begin
    for (int i = 0; i < MAX_AXES; i++) begin
      hit[i] = (COUNT_W'(i) < n_used) && (axis_code_r[i] == in_code);
    end
  end

  // Take the first matching slot in list order
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = MAX_AXES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_any = 1'b1;
        match_idx = AXW'(i);
      end
    end
  end

  // Classify the item on the input port
  always_comb begin
    cls = CLS_PASS;
    if (in_type == event_type_r) begin
      if (unpack_mode_r) begin
        if (in_code == combined_code_r) begin
          cls = (n_used == '0) ? CLS_CONSUME : CLS_UNPACK;
        end
      end else if (match_any) begin
        cls = in_sync ? CLS_PACK : CLS_CONSUME;
      end
    end
  end

  assign store_en = cmd.take && !unpack_mode_r && (cls == CLS_CONSUME || cls == CLS_PACK);
  assign axis_sel = axis_code_r[2'(idx_r)];
  assign held_sel = held_r[idx_r];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_type_r    <= EVENT_TYPE_RST;
      unpack_mode_r   <= UNPACK_MODE_RST;
      combined_code_r <= COMBINED_CODE_RST;
      code_count_r    <= CODE_COUNT_RST;
      axis_code_r[0]  <= AXIS_CODE_0_RST;
      axis_code_r[1]  <= AXIS_CODE_1_RST;
      axis_code_r[2]  <= AXIS_CODE_2_RST;
      axis_code_r[3]  <= AXIS_CODE_3_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_EVENT_TYPE:    event_type_r    <= cfg_data[TYPE_W-1:0];
        REG_UNPACK_MODE:   unpack_mode_r   <= cfg_data[0];
        REG_COMBINED_CODE: combined_code_r <= cfg_data[CODE_W-1:0];
        REG_CODE_COUNT:    code_count_r    <= cfg_data[COUNT_W-1:0];
        REG_AXIS_CODE_0:   axis_code_r[0]  <= cfg_data[CODE_W-1:0];
        REG_AXIS_CODE_1:   axis_code_r[1]  <= cfg_data[CODE_W-1:0];
        REG_AXIS_CODE_2:   axis_code_r[2]  <= cfg_data[CODE_W-1:0];
        REG_AXIS_CODE_3:   axis_code_r[3]  <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Delta store: write on a matched delta, clear each slot as it is packed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        held_r[i] <= '0;
      end
    end else if (store_en) begin
      held_r[match_idx] <= in_value[HALF_W-1:0];
    end else if (cmd.pack_step) begin
      held_r[idx_r] <= '0;
    end
  end

  // Working word and slot index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.take) begin
      type_r <= in_type;
      if (cls == CLS_UNPACK) begin
        word_r <= in_value;
        idx_r  <= AXW'(n_m1);
      end else begin
        word_r <= '0;
        idx_r  <= '0;
      end
    end else if (cmd.pack_step) begin
      word_r <= {word_r[VALUE_W-HALF_W-1:0], held_sel};
      idx_r  <= idx_r + AXW'(1);
    end else if (cmd.report) begin
      word_r <= word_r >> HALF_W;
      idx_r  <= idx_r - AXW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_type_r <= in_type;
      out_code_r <= in_code;
      out_sync_r <= in_sync;
      out_last_r <= 1'b1;
      if (cls == CLS_CONSUME) begin
        out_disp_r  <= DISP_CONSUME;
        out_value_r <= '0;
      end else begin
        out_disp_r  <= DISP_PASS;
        out_value_r <= in_value;
      end
    end else if (cmd.pack_step && st.idx_top) begin
      out_disp_r  <= DISP_PASS;
      out_type_r  <= type_r;
      out_code_r  <= combined_code_r;
      out_value_r <= {word_r[VALUE_W-HALF_W-1:0], held_sel};
      out_sync_r  <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (cmd.report) begin
      out_disp_r  <= DISP_REPORT;
      out_type_r  <= event_type_r;
      out_code_r  <= axis_sel;
      out_value_r <= {{(VALUE_W-HALF_W){1'b0}}, word_r[HALF_W-1:0]};
      out_sync_r  <= (idx_r == '0);
      out_last_r  <= (idx_r == '0);
    end
  end

  assign out_disp  = out_disp_r;
  assign out_type  = out_type_r;
  assign out_code  = out_code_r;
  assign out_value = out_value_r;
  assign out_sync  = out_sync_r;
  assign out_last  = out_last_r;

  // Status to the controller
  always_comb begin
    st.cls      = cls;
    st.idx_top  = (COUNT_W'(idx_r) == n_m1);
    st.out_last = out_last_r;
  end

endmodule

`default_nettype wire

>>> rtl/axis_delta_packer_unpacker.sv
// Top level of the axis delta packer/unpacker: stream ports, field packing,
// adpu_ctrl and adpu_dp. Depends on adpu_pkg.
`default_nettype none

// Handles one event item at a time. Some items give a single result, offered
// the cycle after the item is accepted: an event of another type, an
// unmatched code, a pack-mode delta without sync, and an unpack-mode combined
// event while the code count is zero. Let n be code_count capped at MAX_AXES.
// A pack-mode sync sweeps the delta store one slot a cycle in ST_PACK, and
// the final slot loads the packed result. An unpack-mode combined event gives
// n reports: ST_EMIT loads the first, and each later one is loaded as the
// one before it is taken in ST_OUT. The single output register holds each
// result until it is taken, and no new item is accepted before the last
// result of the current one leaves. Configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while the block is idle.
module axis_delta_packer_unpacker
  import adpu_pkg::*;
#(
  parameter int MAX_AXES = MAX_AXES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [DATA_W-1:0]     in_tdata,   // in_code [15:0], in_value [47:16]
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // in_type [7:0]
  input  wire logic                  in_tlast,   // in_sync
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DATA_W-1:0]          out_tdata,  // out_code [15:0], out_value [47:16]
  output logic [OUT_USER_W-1:0]      out_tuser,  // disposition [1:0], out_type [9:2],
                                                 // out_sync [10]
  output logic                       out_tlast   // last
);

  dp_cmd_t            cmd;
  dp_stat_t           st;
  disp_t              out_disp;
  logic [TYPE_W-1:0]  out_type;
  logic [CODE_W-1:0]  out_code;
  logic [VALUE_W-1:0] out_value;
  logic               out_sync;
  logic               out_last;

  adpu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  adpu_dp #(
    .MAX_AXES (MAX_AXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_type   (in_tuser[TYPE_W-1:0]),
    .in_code   (in_tdata[CODE_W-1:0]),
    .in_value  (in_tdata[DATA_W-1:CODE_W]),
    .in_sync   (in_tlast),
    .out_disp  (out_disp),
    .out_type  (out_type),
    .out_code  (out_code),
    .out_value (out_value),
    .out_sync  (out_sync),
    .out_last  (out_last),
    .cmd       (cmd),
    .st        (st)
  );

  // Pack result fields onto the stream
  assign out_tdata = {out_value, out_code};
  assign out_tuser = {out_sync, out_type, out_disp};
  assign out_tlast = out_last;

`ifndef SYNTHESIS
  // Never offer a result while taking a new item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // An accepted item keeps the input closed on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened straight after an item");

  // More reports follow a result that is not the last
  a_more_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && !in_tready))
    else $error("report sequence cut short");
`endif

endmodule

`default_nettype wire
